// ===== hdl/lkvt_pkg.sv =====
// package for the linear key/value table
// command, status and cell operation codes plus parameter defaults
// no dependencies
`timescale 1ns / 1ps

package lkvt_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // command codes
    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_ACCESS = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_HIT  = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_NEW  = 2'd2;
    localparam logic [1:0] STAT_FULL = 2'd3;

    // operation broadcast to the cells in the update cycle
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_NONE   = 2'd0;
    localparam cell_op_t OP_WRITE  = 2'd1;
    localparam cell_op_t OP_APPEND = 2'd2;
    localparam cell_op_t OP_DELETE = 2'd3;

    typedef struct packed {
        logic     cmp_en;   // compare broadcast key this cycle
        cell_op_t op;       // update applied this cycle
    } cell_ctrl_t;

endpackage

// ===== hdl/linear_key_value_table.sv =====
// linear key/value table: each transaction passes accept, reduce and update in turn
// the or-fold over all cells is registered in reduce; the single update broadcast
// registers the result and waits while a stalled result still holds the output
// the next command is taken once the update of the previous one has landed
// async active-low reset empties the table; stored keys and values are not cleared
// depends on lkvt_pkg, lkvt_cell, lkvt_reduce
`timescale 1ns / 1ps

module linear_key_value_table
    import lkvt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CntW      = $clog2(DEPTH + 1),
    localparam int SlotW     = $clog2(DEPTH)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   command,
    input  logic signed [KEY_BITS-1:0]   key,
    input  logic signed [VALUE_BITS-1:0] write_value,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] read_value,
    output logic [1:0]                   status,
    output logic [CntW-1:0]              entry_count
);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CntW-1:0]       count_reg, count_next;
    logic [2:0]            cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] wv_reg;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] rv_reg, rv_next;
    logic [1:0]            stat_reg, stat_next;

    logic                  in_fire;
    logic                  apply_go;
    cell_ctrl_t            ctrl;
    cell_op_t              op_next;
    logic [VALUE_BITS-1:0] new_value;

    // per-cell wiring
    logic [KEY_BITS-1:0]   cell_key   [DEPTH];
    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]      cell_match;

    logic                  hit;
    logic [SlotW-1:0]      slot;
    logic [VALUE_BITS-1:0] hit_value;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    // update waits until the output register is free
    assign apply_go = (state_reg == S_APPLY) && (!out_valid_reg || !out_stall);

    // command decision, evaluated in the update cycle
    always_comb
    begin
        op_next    = OP_NONE;
        count_next = count_reg;
        rv_next    = '0;
        stat_next  = STAT_HIT;
        new_value  = wv_reg;
        unique case (cmd_reg) inside
            CMD_ACCESS, CMD_WRITE:
            begin
                if (cmd_reg == CMD_ACCESS)
                begin
                    new_value = '0;
                end
                if (hit)
                begin
                    op_next   = (cmd_reg == CMD_WRITE) ? OP_WRITE : OP_NONE;
                    rv_next   = (cmd_reg == CMD_WRITE) ? wv_reg : hit_value;
                    stat_next = STAT_HIT;
                end
                else if (count_reg == CntW'(DEPTH))
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    op_next    = OP_APPEND;
                    rv_next    = new_value;
                    count_next = count_reg + 1'b1;
                    stat_next  = STAT_NEW;
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    op_next    = OP_DELETE;
                    count_next = count_reg - 1'b1;
                    stat_next  = STAT_HIT;
                end
                else
                begin
                    stat_next = STAT_MISS;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
                stat_next  = STAT_HIT;
            end
            default:
            begin
                // lookup and the unused codes
                rv_next   = hit ? hit_value : '0;
                stat_next = hit ? STAT_HIT : STAT_MISS;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = in_fire ? S_REDUCE : S_IDLE;
            S_REDUCE: state_next = S_APPLY;
            S_APPLY:  state_next = apply_go ? S_IDLE : S_APPLY;
            default:  state_next = S_IDLE;
        endcase
    end

    assign ctrl.cmp_en = in_fire;
    assign ctrl.op     = apply_go ? op_next : OP_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= command;
            key_reg <= key;
            wv_reg  <= write_value;
        end
        if (apply_go)
        begin
            rv_reg   <= rv_next;
            stat_reg <= stat_next;
        end
    end

    // row of entry cells, each fed by its upper neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]   nb_key;
        logic [VALUE_BITS-1:0] nb_value;

        if (i == DEPTH - 1)
        begin : g_top
            assign nb_key   = '0;
            assign nb_value = '0;
        end
        else
        begin : g_mid
            assign nb_key   = cell_key[i+1];
            assign nb_value = cell_value[i+1];
        end

        lkvt_cell #(
            .DEPTH      (DEPTH),
            .IDX        (i),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count_reg),
            .slot      (slot),
            .cmp_key   (key),
            .new_key   (key_reg),
            .new_value (new_value),
            .nb_key    (nb_key),
            .nb_value  (nb_value),
            .key_q     (cell_key[i]),
            .value_q   (cell_value[i]),
            .match_q   (cell_match[i])
        );
    end

    lkvt_reduce #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_reduce (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (state_reg == S_REDUCE),
        .match  (cell_match),
        .values (cell_value),
        .hit    (hit),
        .slot   (slot),
        .value  (hit_value)
    );

    assign out_valid   = out_valid_reg;
    assign read_value  = rv_reg;
    assign status      = stat_reg;
    assign entry_count = count_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("entry count above capacity");

    a_unique_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE) |-> $onehot0(cell_match))
        else $error("more than one entry matches the key");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stat_reg == STAT_FULL) |-> (count_reg == CntW'(DEPTH)))
        else $error("full status reported on a table with room");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(count_reg)))
        else $error("count changed under a stalled result");

endmodule

// ===== hdl/lkvt_cell.sv =====
// one table entry: key, value and registered match flag
// depends on lkvt_pkg; chained to its upper neighbor for delete shifts
`timescale 1ns / 1ps

module lkvt_cell
    import lkvt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int IDX        = 0,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CntW      = $clog2(DEPTH + 1),
    localparam int SlotW     = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [CntW-1:0]       count,
    input  logic [SlotW-1:0]      slot,
    input  logic [KEY_BITS-1:0]   cmp_key,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic [KEY_BITS-1:0]   nb_key,
    input  logic [VALUE_BITS-1:0] nb_value,
    output logic [KEY_BITS-1:0]   key_q,
    output logic [VALUE_BITS-1:0] value_q,
    output logic                  match_q
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  match_reg;
    logic                  occupied;

    assign occupied = CntW'(IDX) < count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            match_reg <= occupied && (key_reg == cmp_key);
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_WRITE:
            begin
                if (match_reg)
                begin
                    value_reg <= new_value;
                end
            end
            OP_APPEND:
            begin
                if (count == CntW'(IDX))
                begin
                    key_reg   <= new_key;
                    value_reg <= new_value;
                end
            end
            OP_DELETE:
            begin
                // entries at and above the removed one move down
                if (slot <= SlotW'(IDX))
                begin
                    key_reg   <= nb_key;
                    value_reg <= nb_value;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;
    assign match_q = match_reg;

endmodule

// ===== hdl/lkvt_reduce.sv =====
// folds the one-hot match flags of all cells into hit, slot and value
// depends on lkvt_pkg; registered result
`timescale 1ns / 1ps

module lkvt_reduce
    import lkvt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int SlotW     = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [DEPTH-1:0]      match,
    input  logic [VALUE_BITS-1:0] values [DEPTH],
    output logic                  hit,
    output logic [SlotW-1:0]      slot,
    output logic [VALUE_BITS-1:0] value
);

    logic                  hit_reg;
    logic [SlotW-1:0]      slot_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [SlotW-1:0]      slot_next;
    logic [VALUE_BITS-1:0] value_next;

    // keys are unique, so at most one flag is set and a plain or-fold works
    always_comb
    begin
        slot_next  = '0;
        value_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_next  = slot_next  | (match[i] ? SlotW'(i) : '0);
            value_next = value_next | (match[i] ? values[i] : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (load)
        begin
            hit_reg <= |match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg  <= slot_next;
            value_reg <= value_next;
        end
    end

    assign hit   = hit_reg;
    assign slot  = slot_reg;
    assign value = value_reg;

endmodule

// ===== test/linear_key_value_table_tb.sv =====
// testbench for linear_key_value_table: directed table walk then random command episodes
// results are checked against an in-bench table predictor or typed row results; depends on lkvt_pkg and the rtl
`timescale 1ns / 1ps

module linear_key_value_table_tb;
    import lkvt_pkg::*;

    localparam int TableDepth    = DEPTH_DEF;
    localparam int KeyW          = KEY_BITS_DEF;
    localparam int ValW          = VALUE_BITS_DEF;
    localparam int CntW          = $clog2(TableDepth + 1);
    localparam int RandomItems   = 750;
    localparam int LongHold      = 200;
    localparam int WatchdogLimit = 3000;
    localparam int SettleCycles  = 12;

    // corner bit patterns for keys and values
    localparam logic [31:0] MostNeg = 32'h8000_0000;
    localparam logic [31:0] MostPos = 32'h7fff_ffff;
    localparam logic [31:0] AllOnes = 32'hffff_ffff;

    // one result transaction as seen on the output port
    typedef struct packed {
        logic [ValW-1:0] value;
        logic [1:0]      stat;
        logic [CntW-1:0] count;
    } table_result_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [2:0]      cmd;
        logic [KeyW-1:0] k;
        logic [ValW-1:0] wv;
        logic            typed;
        logic [ValW-1:0] exp_value;
        logic [1:0]      exp_stat;
        logic [CntW-1:0] exp_count;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [2:0]             command;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] write_value;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [ValW-1:0] read_value;
    logic [1:0]             status;
    logic [CntW-1:0]        entry_count;

    // predictor copy of the table contents
    logic [KeyW-1:0] held_keys   [TableDepth];
    logic [ValW-1:0] held_values [TableDepth];
    int              held_count;

    table_result_t   pending_results [$];
    directed_row_t   directed_rows [$];
    int              check_failures;
    int              commands_sent;

    // idle modes per side, switched per episode so some stretches run back to back
    bit              tx_idle;
    bit              rx_idle;
    // asks the receiver for one long stall so the block backs up
    bit              hold_req;

    linear_key_value_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .key         (key),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // table predictor: search, then update as the command asks, one result per command
    function automatic table_result_t apply_table_command(
        input logic [2:0]      cmd,
        input logic [KeyW-1:0] k,
        input logic [ValW-1:0] wv
    );
        table_result_t r;
        int            slot;
        slot = -1;
        // first matching entry wins, entries are in insertion order
        for (int i = 0; i < held_count; i++)
        begin
            if (slot < 0 && held_keys[i] == k)
                slot = i;
        end
        r.value = '0;
        r.stat  = STAT_HIT;
        case (cmd) inside
            CMD_ACCESS, CMD_WRITE:
            begin
                if (slot >= 0)
                begin
                    if (cmd == CMD_WRITE)
                        held_values[slot] = wv;
                    r.value = held_values[slot];
                end
                else if (held_count >= TableDepth)
                begin
                    // full table refuses the append
                    r.stat = STAT_FULL;
                end
                else
                begin
                    held_keys[held_count]   = k;
                    held_values[held_count] = (cmd == CMD_WRITE) ? wv : '0;
                    r.value                 = held_values[held_count];
                    held_count++;
                    r.stat = STAT_NEW;
                end
            end
            CMD_DELETE:
            begin
                if (slot >= 0)
                begin
                    // close the gap, later entries move down one place
                    for (int i = slot; i < held_count - 1; i++)
                    begin
                        held_keys[i]   = held_keys[i + 1];
                        held_values[i] = held_values[i + 1];
                    end
                    held_count--;
                end
                else
                begin
                    // missing key leaves the count alone
                    r.stat = STAT_MISS;
                end
            end
            CMD_CLEAR:
                held_count = 0;
            default:
            begin
                // lookup, and the unused codes behave the same
                if (slot >= 0)
                    r.value = held_values[slot];
                else
                    r.stat = STAT_MISS;
            end
        endcase
        r.count = CntW'(held_count);
        return r;
    endfunction

    // mostly random bits, now and then a corner pattern
    function automatic logic [31:0] pick_word();
        case ($urandom_range(15, 0))
            0:       return MostNeg;
            1:       return MostPos;
            2:       return AllOnes;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // drive one command transaction; called and returns at a falling edge
    // valid stays high on return so back-to-back transactions need no dip
    task automatic offer_command(
        input logic [2:0]      cmd,
        input logic [KeyW-1:0] k,
        input logic [ValW-1:0] wv,
        input logic            typed,
        input table_result_t   typed_res
    );
        int            gap;
        table_result_t predicted;
        gap = tx_idle ? $urandom_range(14, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        key         <= k;
        write_value <= wv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge: predictor always advances, typed rows override the result
        predicted = apply_table_command(cmd, k, wv);
        pending_results.push_back(typed ? typed_res : predicted);
        commands_sent++;
        @(negedge clk);
    endtask

    // drop valid and hold off until every outstanding result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // random commands over a small pool of keys so hits, deletes and re-inserts are common
    task automatic run_pool_episode(input int pool_size, input int length);
        logic [KeyW-1:0] pool [64];
        logic [KeyW-1:0] k;
        logic [2:0]      cmd;
        int              pick;
        for (int i = 0; i < 64; i++)
            pool[i] = pick_word();
        repeat (length)
        begin
            k = pool[$urandom_range(pool_size - 1, 0)];
            if ($urandom_range(19, 0) == 0)
                k = $urandom;
            pick = $urandom_range(99, 0);
            if (pick < 22)
                cmd = CMD_LOOKUP;
            else if (pick < 44)
                cmd = CMD_ACCESS;
            else if (pick < 70)
                cmd = CMD_WRITE;
            else if (pick < 90)
                cmd = CMD_DELETE;
            else if (pick < 93)
                cmd = CMD_CLEAR;
            else
                cmd = 3'($urandom_range(7, 5));
            offer_command(cmd, k, pick_word(), 1'b0, '0);
        end
    endtask

    // clear, fill to capacity with distinct keys, then work on the full table
    task automatic fill_table();
        logic [KeyW-1:0] base;
        logic [KeyW-1:0] k;
        logic [2:0]      cmd;
        int              pick;
        base = $urandom;
        offer_command(CMD_CLEAR, $urandom, $urandom, 1'b0, '0);
        for (int i = 0; i < TableDepth; i++)
        begin
            cmd = $urandom_range(1, 0) ? CMD_WRITE : CMD_ACCESS;
            offer_command(cmd, base ^ KeyW'(i), $urandom, 1'b0, '0);
            if ($urandom_range(7, 0) == 0)
                offer_command(CMD_LOOKUP, base ^ KeyW'($urandom_range(i, 0)), $urandom,
                              1'b0, '0);
        end
        // full: misses get refused, a delete frees one place for the next append
        repeat (40)
        begin
            k = $urandom_range(1, 0) ? base ^ KeyW'($urandom_range(TableDepth - 1, 0))
                                     : $urandom;
            pick = $urandom_range(99, 0);
            if (pick < 20)
                cmd = CMD_LOOKUP;
            else if (pick < 50)
                cmd = CMD_ACCESS;
            else if (pick < 85)
                cmd = CMD_WRITE;
            else
                cmd = CMD_DELETE;
            offer_command(cmd, k, pick_word(), 1'b0, '0);
        end
    endtask

    // receiver: per result a random stall, or one long hold when asked
    initial
    begin : result_sink
        int wait_cycles;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // long hold counted here while the sender keeps offering
                out_stall <= 1'b1;
                repeat (LongHold) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                wait_cycles = rx_idle ? $urandom_range(14, 0) : 0;
                if (wait_cycles > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // compare each accepted result with the oldest expectation, field by field
    always @(posedge clk)
    begin : result_check
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: read_value %h status %0d entry_count %0d",
                       read_value, status, entry_count);
                check_failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.value)
                begin
                    $error("read_value expected %h actual %h", want.value, read_value);
                    check_failures++;
                end
                if (status !== want.stat)
                begin
                    $error("status expected %0d actual %0d", want.stat, status);
                    check_failures++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count expected %0d actual %0d", want.count, entry_count);
                    check_failures++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either side ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        table_result_t row_res;
        int            episode;
        rst_n          = 1'b0;
        in_valid       <= 1'b0;
        command        <= CMD_LOOKUP;
        key            <= '0;
        write_value    <= '0;
        check_failures = 0;
        commands_sent  = 0;
        held_count     = 0;
        hold_req       = 1'b0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;

        // directed table: cmd, key, write value, typed, expected value, status, count
        // empty table after reset, delete of a missing key on an empty table
        directed_rows.push_back('{CMD_LOOKUP, 32'h0, 32'h0, 1'b1, 32'h0, STAT_MISS, 0});
        directed_rows.push_back('{CMD_DELETE, 32'h0, 32'h0, 1'b1, 32'h0, STAT_MISS, 0});
        // appends with extreme keys and values
        directed_rows.push_back('{CMD_WRITE, MostNeg, MostPos, 1'b1, MostPos, STAT_NEW, 1});
        directed_rows.push_back('{CMD_ACCESS, MostPos, AllOnes, 1'b1, 32'h0, STAT_NEW, 2});
        directed_rows.push_back('{CMD_WRITE, AllOnes, MostNeg, 1'b1, MostNeg, STAT_NEW, 3});
        directed_rows.push_back('{CMD_WRITE, 32'h0, AllOnes, 1'b1, AllOnes, STAT_NEW, 4});
        // hits and misses on a populated table
        directed_rows.push_back('{CMD_LOOKUP, MostNeg, 32'h0, 1'b1, MostPos, STAT_HIT, 4});
        directed_rows.push_back('{CMD_LOOKUP, 32'h1234_5678, 32'h0, 1'b1, 32'h0, STAT_MISS, 4});
        directed_rows.push_back('{CMD_ACCESS, AllOnes, 32'h0, 1'b1, MostNeg, STAT_HIT, 4});
        directed_rows.push_back('{CMD_WRITE, MostPos, 32'h5a5a_5a5a, 1'b1, 32'h5a5a_5a5a,
                                  STAT_HIT, 4});
        // delete of a missing key must not change the count
        directed_rows.push_back('{CMD_DELETE, 32'h0000_ffff, 32'h0, 1'b1, 32'h0, STAT_MISS, 4});
        // delete of the first entry shifts the rest down
        directed_rows.push_back('{CMD_DELETE, MostNeg, 32'h0, 1'b1, 32'h0, STAT_HIT, 3});
        directed_rows.push_back('{CMD_LOOKUP, MostNeg, 32'h0, 1'b1, 32'h0, STAT_MISS, 3});
        directed_rows.push_back('{CMD_LOOKUP, 32'h0, 32'h0, 1'b1, AllOnes, STAT_HIT, 3});
        // unused codes act as lookup
        directed_rows.push_back('{3'd5, AllOnes, 32'h0, 1'b0, 32'h0, STAT_HIT, 0});
        directed_rows.push_back('{3'd6, 32'h1111_1111, AllOnes, 1'b0, 32'h0, STAT_HIT, 0});
        directed_rows.push_back('{3'd7, MostPos, 32'h0, 1'b0, 32'h0, STAT_HIT, 0});
        // append, then delete the first entry
        directed_rows.push_back('{CMD_ACCESS, 32'h5555_5555, 32'h0, 1'b0, 32'h0, STAT_HIT, 0});
        directed_rows.push_back('{CMD_DELETE, MostPos, 32'h0, 1'b0, 32'h0, STAT_HIT, 0});
        directed_rows.push_back('{CMD_LOOKUP, 32'h5555_5555, 32'h0, 1'b0, 32'h0, STAT_HIT, 0});
        // clear, then the table behaves as fresh
        directed_rows.push_back('{CMD_CLEAR, 32'h0f0f_0f0f, 32'h0, 1'b1, 32'h0, STAT_HIT, 0});
        directed_rows.push_back('{CMD_LOOKUP, AllOnes, 32'h0, 1'b1, 32'h0, STAT_MISS, 0});
        directed_rows.push_back('{CMD_ACCESS, 32'haaaa_aaaa, 32'h0, 1'b1, 32'h0, STAT_NEW, 1});
        directed_rows.push_back('{CMD_CLEAR, 32'h0, AllOnes, 1'b1, 32'h0, STAT_HIT, 0});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            row_res = '{directed_rows[i].exp_value, directed_rows[i].exp_stat,
                        directed_rows[i].exp_count};
            offer_command(directed_rows[i].cmd, directed_rows[i].k, directed_rows[i].wv,
                          directed_rows[i].typed, row_res);
        end
        wait_drained();

        // random episodes until enough commands have gone in
        episode = 0;
        while (commands_sent < directed_rows.size() + RandomItems)
        begin
            tx_idle = ($urandom_range(3, 0) != 0);
            rx_idle = ($urandom_range(3, 0) != 0);
            if (episode == 2)
                fill_table();
            else
            begin
                if (episode == 4)
                begin
                    // sender runs flat out into a long receiver hold
                    hold_req = 1'b1;
                    tx_idle  = 1'b0;
                end
                case ($urandom_range(2, 0))
                    0:       run_pool_episode(4, $urandom_range(60, 30));
                    1:       run_pool_episode(16, $urandom_range(60, 30));
                    default: run_pool_episode(64, $urandom_range(60, 30));
                endcase
            end
            if (episode == 4 || $urandom_range(2, 0) == 0)
                wait_drained();
            episode++;
        end

        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        if (check_failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
